// ----- src/mbrr_pkg.sv -----
// shared constants and helpers for the modbus read-register responder
// no dependencies; used by the interfaces, the top level and the checker
package mbrr_pkg;

  localparam int REQUEST_LENGTH = 8;

  localparam int BYTE_W  = 8;
  localparam int TEMP_W  = 8;
  localparam int HUM_W   = 8;
  localparam int GAS_W   = 12;
  localparam int CRC_W   = 16;
  localparam int IDX_W   = 4;
  localparam int COUNT_W = 3;

  localparam logic [COUNT_W-1:0] REQ_LAST = COUNT_W'(REQUEST_LENGTH - 1);

  localparam logic [BYTE_W-1:0] FUNC_READ_HOLDING = 8'd3;
  localparam logic [BYTE_W-1:0] RESP_BYTE_COUNT   = 8'd6;
  localparam logic [CRC_W-1:0]  CRC_INIT          = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY          = 16'hA001;

  // response byte positions
  localparam logic [IDX_W-1:0] IDX_ADDR    = 4'd0;
  localparam logic [IDX_W-1:0] IDX_FUNC    = 4'd1;
  localparam logic [IDX_W-1:0] IDX_COUNT   = 4'd2;
  localparam logic [IDX_W-1:0] IDX_TEMP_HI = 4'd3;
  localparam logic [IDX_W-1:0] IDX_TEMP_LO = 4'd4;
  localparam logic [IDX_W-1:0] IDX_HUM_HI  = 4'd5;
  localparam logic [IDX_W-1:0] IDX_HUM_LO  = 4'd6;
  localparam logic [IDX_W-1:0] IDX_GAS_HI  = 4'd7;
  localparam logic [IDX_W-1:0] IDX_GAS_LO  = 4'd8;
  localparam logic [IDX_W-1:0] IDX_CRC_LO  = 4'd9;
  localparam logic [IDX_W-1:0] IDX_CRC_HI  = 4'd10;

  // byte of the response frame at a given position
  function automatic logic [BYTE_W-1:0] resp_byte(
    input logic [IDX_W-1:0]  idx,
    input logic [BYTE_W-1:0] addr,
    input logic [TEMP_W-1:0] temp,
    input logic [HUM_W-1:0]  hum,
    input logic [GAS_W-1:0]  gas,
    input logic [CRC_W-1:0]  crc
  );
    logic [CRC_W-1:0] gas_word;
    logic [BYTE_W-1:0] b;
    gas_word = CRC_W'(gas);
    b = '0;
    unique case (idx)
      IDX_ADDR:    b = addr;
      IDX_FUNC:    b = FUNC_READ_HOLDING;
      IDX_COUNT:   b = RESP_BYTE_COUNT;
      IDX_TEMP_HI: b = '0;
      IDX_TEMP_LO: b = temp;
      IDX_HUM_HI:  b = '0;
      IDX_HUM_LO:  b = hum;
      IDX_GAS_HI:  b = gas_word[15:8];
      IDX_GAS_LO:  b = gas_word[7:0];
      IDX_CRC_LO:  b = crc[7:0];
      IDX_CRC_HI:  b = crc[15:8];
      default:     b = '0;
    endcase
    return b;
  endfunction

endpackage

// ----- src/mbrr_if.sv -----
// valid/ready channel interfaces of the modbus read-register responder
// depends on mbrr_pkg for field widths
interface mbrr_req_if import mbrr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] rx_byte;
  logic [TEMP_W-1:0] temp_reading;
  logic [HUM_W-1:0]  humidity_reading;
  logic [GAS_W-1:0]  gas_level;

  modport source (output valid, op, rx_byte, temp_reading, humidity_reading, gas_level,
                  input ready);
  modport sink (input valid, op, rx_byte, temp_reading, humidity_reading, gas_level,
                output ready);
endinterface

interface mbrr_rsp_if import mbrr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] tx_byte;
  logic              frame_end;

  modport source (output valid, tx_byte, frame_end, input ready);
  modport sink (input valid, tx_byte, frame_end, output ready);
endinterface

interface mbrr_cfg_if import mbrr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] slave_address;

  modport source (output valid, slave_address, input ready);
  modport sink (input valid, slave_address, output ready);
endinterface

// ----- src/modbus_read_register_responder.sv -----
// a request byte or measurement load is taken only while no reply is due (idle state)
// a request that completes a matching frame: each reply byte is loaded, the crc-covered
// bytes are shifted bit-serially through the crc, and then each byte is sent;
// the next request is taken only after the final crc byte; one item at a time
// reset (synchronous, rst high) clears frame position, stores, address to 1, output empty
// depends on mbrr_pkg and the channel interfaces in mbrr_if.sv
module modbus_read_register_responder import mbrr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mbrr_req_if.sink   req,
  mbrr_rsp_if.source rsp,
  mbrr_cfg_if.sink   cfg
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOAD  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_SEND  = 4'b1000
  } state_t;

  state_t             state;
  logic [BYTE_W-1:0]  slave_address;
  logic [COUNT_W-1:0] byte_count;
  logic [BYTE_W-1:0]  addr_byte;
  logic [BYTE_W-1:0]  func_byte;
  logic [TEMP_W-1:0]  temp_store;
  logic [HUM_W-1:0]   humidity_store;
  logic [GAS_W-1:0]   gas_store;

  logic [IDX_W-1:0]   idx;
  logic [2:0]         bit_cnt;
  logic [BYTE_W-1:0]  shreg;
  logic [BYTE_W-1:0]  tx_hold;
  logic [CRC_W-1:0]   crc;

  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_end;

  logic               req_fire;
  logic               out_free;
  logic [BYTE_W-1:0]  addr_eff;
  logic [BYTE_W-1:0]  func_eff;
  logic               frame_done;
  logic               frame_match;
  logic [CRC_W-1:0]   crc_shift;
  logic [CRC_W-1:0]   crc_next;
  logic [BYTE_W-1:0]  sel_byte;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid     = out_valid;
  assign rsp.tx_byte   = out_byte;
  assign rsp.frame_end = out_end;

  // the completing byte may itself be the address or function code on short frames
  assign addr_eff    = (byte_count == '0) ? req.rx_byte : addr_byte;
  assign func_eff    = (byte_count == COUNT_W'(1)) ? req.rx_byte : func_byte;
  assign frame_done  = (byte_count >= REQ_LAST);
  assign frame_match = (addr_eff == slave_address) && (func_eff == FUNC_READ_HOLDING);

  // one lsb-first step of the reflected crc
  assign crc_shift = crc >> 1;
  assign crc_next  = (crc[0] ^ shreg[0]) ? (crc_shift ^ CRC_POLY) : crc_shift;

  assign sel_byte = resp_byte(idx, slave_address, temp_store, humidity_store, gas_store, crc);

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
    end else if (cfg.valid && cfg.ready) begin
      slave_address <= cfg.slave_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      byte_count     <= '0;
      addr_byte      <= '0;
      func_byte      <= '0;
      temp_store     <= '0;
      humidity_store <= '0;
      gas_store      <= '0;
      idx            <= '0;
      bit_cnt        <= '0;
      crc            <= CRC_INIT;
      out_valid      <= 1'b0;
    end else begin
      if (state == S_SEND && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req.op) begin
              temp_store     <= req.temp_reading;
              humidity_store <= req.humidity_reading;
              gas_store      <= req.gas_level;
            end else begin
              if (byte_count == '0) begin
                addr_byte <= req.rx_byte;
              end else if (byte_count == COUNT_W'(1)) begin
                func_byte <= req.rx_byte;
              end
              if (!frame_done) begin
                byte_count <= byte_count + COUNT_W'(1);
              end else begin
                byte_count <= '0;
                if (frame_match) begin
                  idx   <= IDX_ADDR;
                  crc   <= CRC_INIT;
                  state <= S_LOAD;
                end
              end
            end
          end
        end
        S_LOAD: begin
          bit_cnt <= '0;
          if (idx < IDX_CRC_LO) begin
            state <= S_SHIFT;
          end else begin
            state <= S_SEND;
          end
        end
        S_SHIFT: begin
          crc     <= crc_next;
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state <= S_SEND;
          end
        end
        S_SEND: begin
          if (out_free) begin
            idx <= idx + IDX_W'(1);
            if (idx == IDX_CRC_HI) begin
              state <= S_IDLE;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload path: byte latch, crc shift register and output word
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      shreg   <= sel_byte;
      tx_hold <= sel_byte;
    end else if (state == S_SHIFT) begin
      shreg <= shreg >> 1;
    end
    if (state == S_SEND && out_free) begin
      out_byte <= tx_hold;
      out_end  <= (idx == IDX_CRC_HI);
    end
  end

endmodule

// ----- src/mbrr_check.sv -----
// port-level checks for the modbus read-register responder
// depends on mbrr_pkg; attached to the top level by the bind below
module mbrr_check import mbrr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [BYTE_W-1:0] rsp_tx_byte,
  input logic              rsp_frame_end
);

  // a stalled word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte))
    else $error("response word changed while stalled");

  // mid-response the block takes no request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_frame_end |-> !req_ready)
    else $error("request taken during a response");

  // nothing follows the final crc byte at once
  a_end_gap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && rsp_frame_end |=> !rsp_valid)
    else $error("word follows frame end directly");

  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("output not empty after reset");

endmodule

bind modbus_read_register_responder mbrr_check u_mbrr_check (
  .clk           (clk),
  .rst           (rst),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_tx_byte   (rsp.tx_byte),
  .rsp_frame_end (rsp.frame_end)
);

// ----- dv/mbrr_reply_checker.sv -----
`timescale 1ns / 100ps
// reply checker for the modbus read-register responder: watches the request, config
// and response channels, predicts every reply frame and compares it word by word
// depends on mbrr_pkg and the channel interfaces in mbrr_if.sv
package mbrr_tb_pkg;

  typedef enum logic {
    OP_RX_BYTE = 1'b0,
    OP_LOAD    = 1'b1
  } op_e;

endpackage

module mbrr_reply_checker
  import mbrr_pkg::*;
  import mbrr_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mbrr_req_if         req,
  mbrr_rsp_if         rsp,
  mbrr_cfg_if         cfg,
  output int unsigned mismatches,
  output int unsigned replies_due
);

  localparam int REPLY_LEN = 11;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } reply_word_t;

  reply_word_t        reply_q[$];
  logic [BYTE_W-1:0]  own_addr;
  logic [COUNT_W-1:0] frame_pos;
  logic [BYTE_W-1:0]  addr_seen;
  logic [BYTE_W-1:0]  func_seen;
  logic [TEMP_W-1:0]  temp_held;
  logic [HUM_W-1:0]   hum_held;
  logic [GAS_W-1:0]   gas_held;

  // crc-16 over one byte, reflected polynomial, lsb first
  function automatic logic [CRC_W-1:0] crc16_add(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ CRC_W'(b);
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic take_request();
    logic [BYTE_W-1:0] frame [REPLY_LEN];
    logic [CRC_W-1:0]  crc;
    logic [CRC_W-1:0]  gas_word;
    // a measurement load leaves the frame position alone
    if (op_e'(req.op) == OP_LOAD) begin
      temp_held = req.temp_reading;
      hum_held  = req.humidity_reading;
      gas_held  = req.gas_level;
      return;
    end
    if (frame_pos == 0) begin
      addr_seen = req.rx_byte;
    end else if (frame_pos == 1) begin
      func_seen = req.rx_byte;
    end
    if (frame_pos < REQ_LAST) begin
      frame_pos = frame_pos + 1'b1;
      return;
    end
    frame_pos = '0;
    // address compared literally, no broadcast
    if (addr_seen != own_addr || func_seen != FUNC_READ_HOLDING) return;
    gas_word  = CRC_W'(gas_held);
    frame[0]  = own_addr;
    frame[1]  = FUNC_READ_HOLDING;
    frame[2]  = RESP_BYTE_COUNT;
    frame[3]  = '0;
    frame[4]  = temp_held;
    frame[5]  = '0;
    frame[6]  = hum_held;
    frame[7]  = gas_word[15:8];
    frame[8]  = gas_word[7:0];
    crc = CRC_INIT;
    for (int k = 0; k < REPLY_LEN - 2; k++) begin
      crc = crc16_add(crc, frame[k]);
    end
    frame[9]  = crc[7:0];
    frame[10] = crc[15:8];
    for (int k = 0; k < REPLY_LEN; k++) begin
      reply_q.push_back(reply_word_t'{data: frame[k], last: (k == REPLY_LEN - 1)});
    end
  endtask

  task automatic check_reply();
    reply_word_t want;
    if (reply_q.size() == 0) begin
      if (mismatches < 10) begin
        $display("%0t: response word 0x%02h frame_end %0b arrived with no reply due",
                 $time, rsp.tx_byte, rsp.frame_end);
      end
      mismatches <= mismatches + 1;
      return;
    end
    want = reply_q.pop_front();
    if (rsp.tx_byte !== want.data || rsp.frame_end !== want.last) begin
      if (mismatches < 10) begin
        $display("%0t: tx_byte exp 0x%02h got 0x%02h, frame_end exp %0b got %0b",
                 $time, want.data, rsp.tx_byte, want.last, rsp.frame_end);
      end
      mismatches <= mismatches + 1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      own_addr  = 8'd1;
      frame_pos = '0;
      addr_seen = '0;
      func_seen = '0;
      temp_held = '0;
      hum_held  = '0;
      gas_held  = '0;
      reply_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) check_reply();
      if (cfg.valid && cfg.ready) own_addr = cfg.slave_address;
      if (req.valid && req.ready) take_request();
    end
    replies_due <= reply_q.size();
  end

endmodule

// ----- dv/modbus_read_register_responder_tb.sv -----
`timescale 1ns / 100ps
// testbench top for the modbus read-register responder: drives request words,
// address writes and response back-pressure, and gives the verdict
// depends on mbrr_pkg, mbrr_if.sv and the reply checker in mbrr_reply_checker.sv
module modbus_read_register_responder_tb;
  import mbrr_pkg::*;
  import mbrr_tb_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PART_ITEMS    = 38;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mbrr_req_if req ();
  mbrr_rsp_if rsp ();
  mbrr_cfg_if cfg ();

  int unsigned       mismatches;
  int unsigned       replies_due;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       quiet_cycles;
  int unsigned       items_sent;
  int unsigned       frame_fill;
  logic [BYTE_W-1:0] bus_addr;

  modbus_read_register_responder i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  mbrr_reply_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .replies_due (replies_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // no word moving on any channel for too long means the block has hung
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input op_e op, input logic [BYTE_W-1:0] rx,
                           input logic [TEMP_W-1:0] temp, input logic [HUM_W-1:0] hum,
                           input logic [GAS_W-1:0] gas);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid   = 1'b0;
      req.rx_byte = BYTE_W'($urandom);
      @(negedge clk);
    end
    req.valid            = 1'b1;
    req.op               = op;
    req.rx_byte          = rx;
    req.temp_reading     = temp;
    req.humidity_reading = hum;
    req.gas_level        = gas;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    items_sent++;
    if (op == OP_RX_BYTE) frame_fill = (frame_fill + 1) % REQUEST_LENGTH;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    send_word(OP_RX_BYTE, b, TEMP_W'($urandom), HUM_W'($urandom), GAS_W'($urandom));
  endtask

  task automatic send_load(input logic [TEMP_W-1:0] temp, input logic [HUM_W-1:0] hum,
                           input logic [GAS_W-1:0] gas);
    send_word(OP_LOAD, BYTE_W'($urandom), temp, hum, gas);
  endtask

  // pads out a partial frame first, then one whole request with loads mixed in
  task automatic send_frame(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] func);
    logic [BYTE_W-1:0] b;
    while (frame_fill != 0) send_byte(BYTE_W'($urandom));
    for (int i = 0; i < REQUEST_LENGTH; i++) begin
      if ($urandom_range(9) == 0) begin
        send_load(TEMP_W'($urandom), HUM_W'($urandom), GAS_W'($urandom));
      end
      case (i)
        0:       b = addr;
        1:       b = func;
        default: b = BYTE_W'($urandom);
      endcase
      send_byte(b);
    end
  endtask

  task automatic hold_until_replied();
    req.valid = 1'b0;
    while (replies_due != 0) @(negedge clk);
  endtask

  task automatic set_address(input logic [BYTE_W-1:0] addr);
    hold_until_replied();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg.valid         = 1'b1;
    cfg.slave_address = addr;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
    bus_addr  = addr;
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned       stop_at;
    int unsigned       pick;
    logic [BYTE_W-1:0] func;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame(bus_addr, FUNC_READ_HOLDING);
      end else if (pick < 65) begin
        send_frame(bus_addr ^ BYTE_W'($urandom_range(1, 255)), FUNC_READ_HOLDING);
      end else if (pick < 75) begin
        do func = BYTE_W'($urandom); while (func == FUNC_READ_HOLDING);
        send_frame(bus_addr, func);
      end else if (pick < 85) begin
        send_load(TEMP_W'($urandom), HUM_W'($urandom), GAS_W'($urandom));
      end else if (pick < 95) begin
        // stray bytes knock the frame alignment about
        repeat ($urandom_range(1, REQUEST_LENGTH)) send_byte(BYTE_W'($urandom));
      end else begin
        hold_until_replied();
      end
    end
  endtask

  initial begin
    req.valid            = 1'b0;
    req.op               = OP_RX_BYTE;
    req.rx_byte          = '0;
    req.temp_reading     = '0;
    req.humidity_reading = '0;
    req.gas_level        = '0;
    rsp.ready            = 1'b0;
    cfg.valid            = 1'b0;
    cfg.slave_address    = '0;
    send_idle_pct        = 22;
    recv_idle_pct        = 72;
    items_sent           = 0;
    frame_fill           = 0;
    bus_addr             = 8'd1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: full-scale load and a request at the reset address, then dropped frames
    send_load('1, '1, '1);
    send_frame(8'd1, FUNC_READ_HOLDING);
    send_frame(8'd1, 8'h83);
    send_frame(8'd2, FUNC_READ_HOLDING);
    send_load('0, '0, '0);

    set_address(8'd247);
    random_traffic(PART_ITEMS);
    set_address(8'd0);
    random_traffic(PART_ITEMS);

    send_idle_pct = 72;
    recv_idle_pct = 22;
    set_address(8'd255);
    random_traffic(PART_ITEMS);
    set_address(BYTE_W'($urandom_range(2, 246)));
    random_traffic(PART_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_address(8'd1);
    random_traffic(PART_ITEMS);
    set_address(BYTE_W'($urandom_range(0, 255)));
    random_traffic(PART_ITEMS);

    hold_until_replied();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && replies_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
